// ===== design/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the SVPWM min-max duty pipeline.
// ----------------------------------------------------------------------------
package smd_pkg;

  // Input transfer: voltage reference and bus voltage
  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
    logic [15:0]        bus_voltage;
  } sample_t;

  // Output transfer: phase duties, modulation index, limit flag
  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [15:0] mod_index;
    logic        limited;
  } result_t;

  // Register indexes
  localparam logic REG_DUTY_MIN = 1'b0;
  localparam logic REG_DUTY_MAX = 1'b1;

  // Q1.15 constants
  localparam logic [15:0] HALF_Q15 = 16'd16384;
  localparam logic [15:0] ONE_Q15  = 16'd32768;

  // sqrt(3)/2 in Q0.16
  localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

  // Datapath widths
  localparam int PH_W = 34;   // phase voltages scaled by 2^16
  localparam int D_W  = 36;   // phase minus zero-sequence term
  localparam int T_W  = 44;   // rounded division numerator

  // Index path: (m3 << 30) / vdc^2, then square root
  localparam int IDX_DW = 63;
  localparam int IDX_VW = 32;
  localparam int IDX_QW = 31;
  localparam int IDX_SQ_W = 32;

  // Duty path: sqrt(m3 << 16), then rounded division per phase
  localparam int DEN_SQ_W = 50;
  localparam int DEN_W    = DEN_SQ_W / 2;
  localparam int DUT_DW   = T_W - 1;
  localparam int DUT_VW   = DEN_W + 1;
  localparam int DUT_QW   = 18;

endpackage

// ===== design/smd_delay.sv =====
// ----------------------------------------------------------------------------
// smd_delay
// Fixed-length register line that keeps side data aligned with long units.
// ----------------------------------------------------------------------------
module smd_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:DEPTH-1];

  // shift one place per cycle
  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// ===== design/smd_div_pipe.sv =====
// ----------------------------------------------------------------------------
// smd_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit in QW bits (dividend >> QW below the divisor).
// ----------------------------------------------------------------------------
module smd_div_pipe #(
  parameter int DW = 16,
  parameter int VW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [VW-1:0] rem [1:QW];
  logic [QW-1:0] lo  [1:QW];
  logic [QW-1:0] quo [1:QW];
  logic [VW-1:0] dv  [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] dv_in;
    logic [VW:0]   rx;
    logic [VW:0]   diff;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = VW'(dividend[DW-1:QW]);
      assign lo_in  = dividend[QW-1:0];
      assign quo_in = '0;
      assign dv_in  = divisor;
    end else begin : g_next
      assign rem_in = rem[s];
      assign lo_in  = lo[s];
      assign quo_in = quo[s];
      assign dv_in  = dv[s];
    end

    // trial subtract of the divisor
    always_comb begin
      rx   = {rem_in, lo_in[QW-1]};
      diff = rx - {1'b0, dv_in};
      take = (rx >= {1'b0, dv_in});
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= take ? diff[VW-1:0] : rx[VW-1:0];
      lo[s+1]  <= {lo_in[QW-2:0], 1'b0};
      quo[s+1] <= {quo_in[QW-2:0], take};
      dv[s+1]  <= dv_in;
    end
  end

  assign quotient = quo[QW];

endmodule

// ===== design/smd_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// smd_isqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// root = floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module smd_isqrt_pipe #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic [W-1:0]     radicand,
  output logic [W/2-1:0]   root
);

  localparam int OW = W / 2;
  localparam int RW = OW + 2;

  logic [RW-1:0] rem [1:OW];
  logic [OW-1:0] rt  [1:OW];
  logic [W-1:0]  xs  [1:OW];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [OW-1:0] rt_in;
    logic [W-1:0]  x_in;
    logic [RW-1:0] rx;
    logic [RW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign x_in   = radicand;
    end else begin : g_next
      assign rem_in = rem[s];
      assign rt_in  = rt[s];
      assign x_in   = xs[s];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      rx    = {rem_in[RW-3:0], x_in[W-1:W-2]};
      trial = {rt_in, 2'b01};
      take  = (rx >= trial);
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= take ? (rx - trial) : rx;
      rt[s+1]  <= {rt_in[OW-2:0], take};
      xs[s+1]  <= {x_in[W-3:0], 2'b00};
    end
  end

  assign root = rt[OW];

endmodule

// ===== design/svpwm_minmax_duty.sv =====
// ----------------------------------------------------------------------------
// svpwm_minmax_duty
// Space-vector PWM duties by min-max zero-sequence injection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present sample (v_alpha, v_beta, bus_voltage) with start
//   high; a transfer happens on every edge with start high and busy low.
//   busy stays low, so a new sample can enter every cycle.
//   Output channel: result is valid for exactly one cycle while done is high;
//   the receiver cannot hold results off.
//   Config: wr_en with wr_index/wr_data writes duty_min (0) or duty_max (1);
//   write only while no transfer is in flight.
// Timing:
//   The index path (a 31-stage divider feeding a 16-stage square root)
//   sets the delay from the input transfer to done; the duty path
//   (25-stage root, 18-stage dividers) is padded to match.
//   Throughput is one sample per cycle.
// Reset:
//   rst clears the valid line and restores duty_min = 0, duty_max = one.
// ----------------------------------------------------------------------------
module svpwm_minmax_duty
  import smd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output result_t     result
);

  localparam int LAT = 4 + IDX_QW + IDX_SQ_W / 2 + 2;
  localparam int DLY_A = DEN_W - 1;

  typedef struct packed {
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
    logic                  over;
    logic                  inv;
    logic [15:0]           vdc;
    logic [15:0]           dmin;
    logic [15:0]           dmax;
  } side_a_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic        over;
    logic        inv;
    logic [15:0] dmin;
    logic [15:0] dmax;
  } side_b_t;

  logic [15:0] duty_min;
  logic [15:0] duty_max;
  logic        accept;
  logic [LAT-2:0] vld;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_min <= 16'd0;
      duty_max <= ONE_Q15;
    end else if (wr_en) begin
      case (wr_index)
        REG_DUTY_MIN: duty_min <= wr_data;
        REG_DUTY_MAX: duty_max <= wr_data;
        default: ;
      endcase
    end
  end

  // valid line, one bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-3:0], accept};
    end
  end

  // R0: capture transfer and setup check
  logic signed [15:0] r0_al, r0_be;
  logic [15:0] r0_vdc, r0_dmin, r0_dmax;
  logic        r0_inv;
  always_ff @(posedge clk) begin
    r0_al   <= sample.v_alpha;
    r0_be   <= sample.v_beta;
    r0_vdc  <= sample.bus_voltage;
    r0_dmin <= duty_min;
    r0_dmax <= duty_max;
    r0_inv  <= (sample.bus_voltage == 16'd0) || (duty_max > ONE_Q15) ||
               (duty_min >= duty_max);
  end

  // R1: products
  logic signed [31:0] sq_a_full, sq_b_full;
  logic signed [33:0] bk_full;
  logic [30:0] r1_sqa, r1_sqb;
  logic [31:0] r1_vdc2;
  logic signed [31:0] r1_bk;
  logic signed [15:0] r1_al;
  logic [15:0] r1_vdc, r1_dmin, r1_dmax;
  logic        r1_inv;
  always_comb begin
    sq_a_full = r0_al * r0_al;
    sq_b_full = r0_be * r0_be;
    bk_full   = r0_be * SQRT3_HALF_Q16;
  end
  always_ff @(posedge clk) begin
    r1_sqa  <= sq_a_full[30:0];
    r1_sqb  <= sq_b_full[30:0];
    r1_vdc2 <= r0_vdc * r0_vdc;
    r1_bk   <= bk_full[31:0];
    r1_al   <= r0_al;
    r1_vdc  <= r0_vdc;
    r1_dmin <= r0_dmin;
    r1_dmax <= r0_dmax;
    r1_inv  <= r0_inv;
  end

  // R2: magnitude sum and inverse Clarke
  logic signed [PH_W-1:0] ax, bkx;
  logic [31:0] r2_sum, r2_vdc2;
  logic signed [PH_W-1:0] r2_ph0, r2_ph1, r2_ph2;
  logic [15:0] r2_vdc, r2_dmin, r2_dmax;
  logic        r2_inv;
  always_comb begin
    ax  = {{3{r1_al[15]}}, r1_al, 15'b0};
    bkx = {{2{r1_bk[31]}}, r1_bk};
  end
  always_ff @(posedge clk) begin
    r2_sum  <= {1'b0, r1_sqa} + {1'b0, r1_sqb};
    r2_ph0  <= {{2{r1_al[15]}}, r1_al, 16'b0};
    r2_ph1  <= bkx - ax;
    r2_ph2  <= -ax - bkx;
    r2_vdc2 <= r1_vdc2;
    r2_vdc  <= r1_vdc;
    r2_dmin <= r1_dmin;
    r2_dmax <= r1_dmax;
    r2_inv  <= r1_inv;
  end

  // R3: m3 = 3*(a^2+b^2), phase max and min
  logic signed [PH_W-1:0] mx01, mn01;
  logic [32:0] r3_m3;
  logic [31:0] r3_vdc2;
  logic signed [PH_W-1:0] r3_ph0, r3_ph1, r3_ph2, r3_mx, r3_mn;
  logic [15:0] r3_vdc, r3_dmin, r3_dmax;
  logic        r3_inv;
  always_comb begin
    mx01 = (r2_ph1 > r2_ph0) ? r2_ph1 : r2_ph0;
    mn01 = (r2_ph1 < r2_ph0) ? r2_ph1 : r2_ph0;
  end
  always_ff @(posedge clk) begin
    r3_m3   <= {1'b0, r2_sum} + {r2_sum, 1'b0};
    r3_mx   <= (r2_ph2 > mx01) ? r2_ph2 : mx01;
    r3_mn   <= (r2_ph2 < mn01) ? r2_ph2 : mn01;
    r3_ph0  <= r2_ph0;
    r3_ph1  <= r2_ph1;
    r3_ph2  <= r2_ph2;
    r3_vdc2 <= r2_vdc2;
    r3_vdc  <= r2_vdc;
    r3_dmin <= r2_dmin;
    r3_dmax <= r2_dmax;
    r3_inv  <= r2_inv;
  end

  // R4: overmodulation test and zero-sequence sum
  logic [32:0] r4_m3;
  logic [31:0] r4_vdc2;
  logic        r4_over;
  logic signed [PH_W:0] r4_mm;
  logic signed [PH_W-1:0] r4_ph0, r4_ph1, r4_ph2;
  logic [15:0] r4_vdc, r4_dmin, r4_dmax;
  logic        r4_inv;
  always_ff @(posedge clk) begin
    r4_m3   <= r3_m3;
    r4_vdc2 <= r3_vdc2;
    r4_over <= r3_m3 > {1'b0, r3_vdc2};
    r4_mm   <= {r3_mx[PH_W-1], r3_mx} + {r3_mn[PH_W-1], r3_mn};
    r4_ph0  <= r3_ph0;
    r4_ph1  <= r3_ph1;
    r4_ph2  <= r3_ph2;
    r4_vdc  <= r3_vdc;
    r4_dmin <= r3_dmin;
    r4_dmax <= r3_dmax;
    r4_inv  <= r3_inv;
  end

  // Index path: floor(sqrt((m3 << 30) / vdc^2))
  logic [IDX_QW-1:0]     idx_quo;
  logic [IDX_SQ_W/2-1:0] idx_root;
  smd_div_pipe #(.DW(IDX_DW), .VW(IDX_VW), .QW(IDX_QW)) u_idx_div (
    .clk      (clk),
    .dividend ({r4_m3, 30'b0}),
    .divisor  (r4_vdc2),
    .quotient (idx_quo)
  );
  smd_isqrt_pipe #(.W(IDX_SQ_W)) u_idx_sqrt (
    .clk      (clk),
    .radicand ({1'b0, idx_quo}),
    .root     (idx_root)
  );

  // Overmodulation denominator: floor(sqrt(m3 << 16))
  logic [DEN_W-1:0] den_root;
  smd_isqrt_pipe #(.W(DEN_SQ_W)) u_den_sqrt (
    .clk      (clk),
    .radicand ({1'b0, r4_m3, 16'b0}),
    .root     (den_root)
  );

  // R5: phase minus zero-sequence term
  side_a_t r5_a, a_dly;
  always_ff @(posedge clk) begin
    r5_a.d0   <= {r4_ph0[PH_W-1], r4_ph0, 1'b0} - {r4_mm[PH_W], r4_mm};
    r5_a.d1   <= {r4_ph1[PH_W-1], r4_ph1, 1'b0} - {r4_mm[PH_W], r4_mm};
    r5_a.d2   <= {r4_ph2[PH_W-1], r4_ph2, 1'b0} - {r4_mm[PH_W], r4_mm};
    r5_a.over <= r4_over;
    r5_a.inv  <= r4_inv;
    r5_a.vdc  <= r4_vdc;
    r5_a.dmin <= r4_dmin;
    r5_a.dmax <= r4_dmax;
  end

  smd_delay #(.W($bits(side_a_t)), .DEPTH(DLY_A)) u_dly_a (
    .clk (clk),
    .d   (r5_a),
    .q   (a_dly)
  );

  // R30: rounded-division operands, sign folded for a floor division
  logic signed [T_W-1:0] t0, t1, t2, den_x, vdc4_x;
  logic [DUT_DW-1:0] r30_mag0, r30_mag1, r30_mag2;
  logic [DUT_VW-1:0] r30_d2;
  side_b_t r30_b, b_dly;
  always_comb begin
    den_x  = T_W'({1'b0, den_root});
    vdc4_x = T_W'({a_dly.vdc, 2'b00});
    t0 = a_dly.over ? ({a_dly.d0[D_W-1], a_dly.d0, 7'b0} + den_x)
                    : ({{7{a_dly.d0[D_W-1]}}, a_dly.d0, 1'b0} + vdc4_x);
    t1 = a_dly.over ? ({a_dly.d1[D_W-1], a_dly.d1, 7'b0} + den_x)
                    : ({{7{a_dly.d1[D_W-1]}}, a_dly.d1, 1'b0} + vdc4_x);
    t2 = a_dly.over ? ({a_dly.d2[D_W-1], a_dly.d2, 7'b0} + den_x)
                    : ({{7{a_dly.d2[D_W-1]}}, a_dly.d2, 1'b0} + vdc4_x);
  end
  always_ff @(posedge clk) begin
    r30_mag0  <= t0[T_W-1] ? ~t0[DUT_DW-1:0] : t0[DUT_DW-1:0];
    r30_mag1  <= t1[T_W-1] ? ~t1[DUT_DW-1:0] : t1[DUT_DW-1:0];
    r30_mag2  <= t2[T_W-1] ? ~t2[DUT_DW-1:0] : t2[DUT_DW-1:0];
    r30_d2    <= a_dly.over ? {den_root, 1'b0} : DUT_VW'({a_dly.vdc, 3'b000});
    r30_b.neg  <= {t2[T_W-1], t1[T_W-1], t0[T_W-1]};
    r30_b.over <= a_dly.over;
    r30_b.inv  <= a_dly.inv;
    r30_b.dmin <= a_dly.dmin;
    r30_b.dmax <= a_dly.dmax;
  end

  logic [DUT_QW-1:0] q0, q1, q2;
  smd_div_pipe #(.DW(DUT_DW), .VW(DUT_VW), .QW(DUT_QW)) u_div_a (
    .clk (clk), .dividend (r30_mag0), .divisor (r30_d2), .quotient (q0)
  );
  smd_div_pipe #(.DW(DUT_DW), .VW(DUT_VW), .QW(DUT_QW)) u_div_b (
    .clk (clk), .dividend (r30_mag1), .divisor (r30_d2), .quotient (q1)
  );
  smd_div_pipe #(.DW(DUT_DW), .VW(DUT_VW), .QW(DUT_QW)) u_div_c (
    .clk (clk), .dividend (r30_mag2), .divisor (r30_d2), .quotient (q2)
  );

  smd_delay #(.W($bits(side_b_t)), .DEPTH(DUT_QW)) u_dly_b (
    .clk (clk),
    .d   (r30_b),
    .q   (b_dly)
  );

  // R49: restore sign, add one half
  logic signed [DUT_QW:0] qs0, qs1, qs2;
  logic signed [DUT_QW+1:0] r49_dp0, r49_dp1, r49_dp2;
  logic        r49_over, r49_inv;
  logic [15:0] r49_dmin, r49_dmax;
  always_comb begin
    qs0 = b_dly.neg[0] ? ~{1'b0, q0} : {1'b0, q0};
    qs1 = b_dly.neg[1] ? ~{1'b0, q1} : {1'b0, q1};
    qs2 = b_dly.neg[2] ? ~{1'b0, q2} : {1'b0, q2};
  end
  always_ff @(posedge clk) begin
    r49_dp0  <= (DUT_QW+2)'(HALF_Q15) + {qs0[DUT_QW], qs0};
    r49_dp1  <= (DUT_QW+2)'(HALF_Q15) + {qs1[DUT_QW], qs1};
    r49_dp2  <= (DUT_QW+2)'(HALF_Q15) + {qs2[DUT_QW], qs2};
    r49_over <= b_dly.over;
    r49_inv  <= b_dly.inv;
    r49_dmin <= b_dly.dmin;
    r49_dmax <= b_dly.dmax;
  end

  // R50: clamp to duty window
  logic signed [DUT_QW+1:0] lo_x, hi_x;
  logic [15:0] r50_du0, r50_du1, r50_du2;
  logic [2:0]  r50_clp;
  logic        r50_over, r50_inv;
  always_comb begin
    lo_x = (DUT_QW+2)'(r49_dmin);
    hi_x = (DUT_QW+2)'(r49_dmax);
  end
  always_ff @(posedge clk) begin
    r50_du0 <= (r49_dp0 < lo_x) ? r49_dmin : (r49_dp0 > hi_x) ? r49_dmax : r49_dp0[15:0];
    r50_du1 <= (r49_dp1 < lo_x) ? r49_dmin : (r49_dp1 > hi_x) ? r49_dmax : r49_dp1[15:0];
    r50_du2 <= (r49_dp2 < lo_x) ? r49_dmin : (r49_dp2 > hi_x) ? r49_dmax : r49_dp2[15:0];
    r50_clp <= {(r49_dp2 < lo_x) || (r49_dp2 > hi_x),
                (r49_dp1 < lo_x) || (r49_dp1 > hi_x),
                (r49_dp0 < lo_x) || (r49_dp0 > hi_x)};
    r50_over <= r49_over;
    r50_inv  <= r49_inv;
  end

  // R51: invalid setup override, limit flag
  logic [15:0] r51_du0, r51_du1, r51_du2;
  logic        r51_lim, r51_over, r51_inv;
  always_ff @(posedge clk) begin
    r51_du0  <= r50_inv ? HALF_Q15 : r50_du0;
    r51_du1  <= r50_inv ? HALF_Q15 : r50_du1;
    r51_du2  <= r50_inv ? HALF_Q15 : r50_du2;
    r51_lim  <= r50_inv || r50_over || (|r50_clp);
    r51_over <= r50_over;
    r51_inv  <= r50_inv;
  end

  // Output register
  always_ff @(posedge clk) begin
    result.duty_a  <= r51_du0;
    result.duty_b  <= r51_du1;
    result.duty_c  <= r51_du2;
    result.limited <= r51_lim;
    if (r51_inv) begin
      result.mod_index <= 16'd0;
    end else if (r51_over || (idx_root > ONE_Q15)) begin
      result.mod_index <= ONE_Q15;
    end else begin
      result.mod_index <= idx_root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-2];
    end
  end

endmodule

// ===== design/smd_checker.sv =====
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks for svpwm_minmax_duty, attached by bind.
// ----------------------------------------------------------------------------
module smd_checker
  import smd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    done,
  input result_t result
);

  // no result transfer right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result transfer right after reset");

  // duties never exceed one
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.duty_a <= ONE_Q15) && (result.duty_b <= ONE_Q15) &&
             (result.duty_c <= ONE_Q15))
    else $error("duty above one");

  // modulation index capped at one
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.mod_index <= ONE_Q15)
    else $error("mod_index above one");

  // negligible reference, no limiting: all duties at one half
  a_zero_ref: assert property (@(posedge clk) disable iff (rst)
    (done && !result.limited && (result.mod_index == 16'd0)) |->
      (result.duty_a == HALF_Q15) && (result.duty_b == HALF_Q15) &&
      (result.duty_c == HALF_Q15))
    else $error("zero reference without half duties");

endmodule

bind svpwm_minmax_duty smd_checker u_smd_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);
